// ===== design/vrrf_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the record ring FIFO.
package vrrf_pkg;

   // Ring geometry: depth is a power of two so pointer wrap is a plain carry-out
   localparam int ADDR_W       = 10;
   localparam int QUEUE_BYTES  = 1 << ADDR_W;
   localparam int HEADER_BYTES = 4;
   localparam int MAX_READ     = 64;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 10;
   localparam int WANT_W   = 7;
   localparam int FREE_W   = ADDR_W + 1;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 2;
   localparam int HDR_W    = BYTE_W * HEADER_BYTES;
   localparam int CNT_W    = $clog2(MAX_READ + 1);
   localparam int IDX_W    = $clog2(HEADER_BYTES + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_NOROOM = 2'd2
   } status_type;

   // One datapath operation per cycle, chosen by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_FILL,
      OP_CLOSE,
      OP_PUSH_CHK,
      OP_HDR,
      OP_DATA,
      OP_PUSH_NF,
      OP_CLEAR,
      OP_RD_START,
      OP_RD_HDR,
      OP_RD_CALC,
      OP_RD_STREAM,
      OP_RESPOND
   } dp_op_type;

   // Datapath status seen by the controller
   typedef struct packed {
      cmd_type cmd;
      logic    fill_needed;
      logic    fits;
      logic    len_zero;
      logic    empty;
      logic    hdr_last;
      logic    hdr_read_done;
      logic    n_zero;
      logic    stream_last;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLOSE,
      S_PUSH_CHK,
      S_HDR,
      S_DATA,
      S_PUSH_NF,
      S_CLEAR,
      S_RD_START,
      S_RD_HDR,
      S_RD_CALC,
      S_STREAM,
      S_RESPOND
   } state_type;

endpackage

// ===== design/variable_record_ring_fifo.sv =====
// Top level of the variable-length record FIFO on a 1024-byte ring.
//
// Usage: an item (push byte, pop, peek or clear) is taken when start is high
// and busy is low. Results come out one beat per cycle, flagged by rsp_valid,
// and cannot be stalled; rsp_last marks the final beat of each item.
// Every record is stored as a 4-byte little-endian length header plus data.
// Steps from accept to the last result, on the ring RAM:
//   push, not first byte : store or drop the byte, then answer
//   push, first byte     : zero-pad an unfinished record, check room,
//                          write the header, then the first byte unless the
//                          length is zero, then answer; if no room, just answer
//   pop / peek           : pad as above; if empty answer, else read the header
//                          one byte per cycle, then stream N bytes (N = bytes
//                          returned, at most 64) one byte per cycle
//   clear                : reset tail and free count, then answer
// A new item can be accepted in the cycle the last result is shown.
// Reset (synchronous) empties the queue and clears pointers and push state;
// ring contents are not cleared and no sweep is needed after reset.
module variable_record_ring_fifo
   import vrrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [BYTE_W-1:0]   req_push_byte,
   input  logic                req_first_of_record,
   input  logic [LEN_W-1:0]    req_record_len,
   input  logic [WANT_W-1:0]   req_max_bytes,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_stored_len,
   output logic [FREE_W-1:0]   rsp_free_bytes
);

   dp_op_type   op;
   dp_stat_type stat;

   vrrf_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_cmd             (req_cmd),
      .req_first_of_record (req_first_of_record),
      .stat                (stat),
      .op                  (op),
      .busy                (busy)
   );

   vrrf_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .req_cmd             (req_cmd),
      .req_push_byte       (req_push_byte),
      .req_record_len      (req_record_len),
      .req_max_bytes       (req_max_bytes),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_last            (rsp_last),
      .rsp_stored_len      (rsp_stored_len),
      .rsp_free_bytes      (rsp_free_bytes)
   );

endmodule

// ===== design/vrrf_ctrl.sv =====
// Controller state machine: sequences push, pop/peek, clear and response beats.
module vrrf_ctrl
   import vrrf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic             req_first_of_record,
   input  dp_stat_type      stat,
   output dp_op_type        op,
   output logic             busy
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op = OP_CAPTURE;
               unique case (cmd_type'(req_cmd))
                  CMD_PUSH: begin
                     state_in = req_first_of_record ? S_CLOSE : S_PUSH_NF;
                  end
                  CMD_POP, CMD_PEEK: begin
                     state_in = S_CLOSE;
                  end
                  CMD_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // Zero-fill a record left short, then drop push state
         S_CLOSE: begin
            if (stat.fill_needed) begin
               op = OP_FILL;
            end else begin
               op       = OP_CLOSE;
               state_in = (stat.cmd == CMD_PUSH) ? S_PUSH_CHK : S_RD_START;
            end
         end
         S_PUSH_CHK: begin
            op       = OP_PUSH_CHK;
            state_in = stat.fits ? S_HDR : S_RESPOND;
         end
         S_HDR: begin
            op = OP_HDR;
            if (stat.hdr_last) begin
               state_in = stat.len_zero ? S_RESPOND : S_DATA;
            end
         end
         S_DATA: begin
            op       = OP_DATA;
            state_in = S_RESPOND;
         end
         S_PUSH_NF: begin
            op       = OP_PUSH_NF;
            state_in = S_RESPOND;
         end
         S_CLEAR: begin
            op       = OP_CLEAR;
            state_in = S_RESPOND;
         end
         S_RD_START: begin
            op       = OP_RD_START;
            state_in = stat.empty ? S_RESPOND : S_RD_HDR;
         end
         S_RD_HDR: begin
            op = OP_RD_HDR;
            if (stat.hdr_read_done) begin
               state_in = S_RD_CALC;
            end
         end
         S_RD_CALC: begin
            op       = OP_RD_CALC;
            state_in = stat.n_zero ? S_RESPOND : S_STREAM;
         end
         S_STREAM: begin
            op = OP_RD_STREAM;
            if (stat.stream_last) begin
               state_in = S_IDLE;
            end
         end
         S_RESPOND: begin
            op       = OP_RESPOND;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/vrrf_dp.sv =====
// Datapath: byte ring memory, pointers, free count, push bookkeeping and result registers.
module vrrf_dp
   import vrrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_op_type           op,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [BYTE_W-1:0]   req_push_byte,
   input  logic [LEN_W-1:0]    req_record_len,
   input  logic [WANT_W-1:0]   req_max_bytes,
   output dp_stat_type         stat,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_stored_len,
   output logic [FREE_W-1:0]   rsp_free_bytes
);

   // Ring storage, one write and one registered read per cycle
   logic [BYTE_W-1:0] ring_mem [QUEUE_BYTES];
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data_ff;

   // Captured request
   cmd_type           cmd_ff, cmd_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WANT_W-1:0] want_ff, want_in;

   // Queue state
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              drop_ff, drop_in;

   // Sequencing
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [HDR_W-1:0]  slen_ff, slen_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic              pend_ff, pend_in;
   status_type        status_ff, status_in;

   // Result registers
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_bvalid_ff, rsp_bvalid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]    rsp_slen_ff, rsp_slen_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   // Derived values
   logic [31:0]       len32;
   logic [HDR_W-1:0]  len_m;
   logic [32:0]       need;
   logic              fits;
   logic [BYTE_W-1:0] hdr_byte;
   logic [31:0]       slen32;
   logic [CNT_W-1:0]  cap;
   logic [CNT_W-1:0]  n_calc;
   logic [17:0]       total;
   logic [31:0]       free_sum;
   logic [LEN_W-1:0]  slen_out;

   // Length as stored in the header, and the space it reserves
   assign len32 = 32'(len_ff);
   assign len_m = len32[HDR_W-1:0];
   assign need  = 33'(len_m) + 33'(HEADER_BYTES);
   assign fits  = !(33'(free_ff) < need);

   // Header byte for the current write slot
   always_comb begin
      hdr_byte = '0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            hdr_byte = len_m[BYTE_W*i +: BYTE_W];
         end
      end
   end

   // Read count: stored length capped by the request and by MAX_READ
   assign slen32   = 32'(slen_ff);
   assign cap      = (32'(want_ff) > 32'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(want_ff);
   assign n_calc   = (slen32 < 32'(cap)) ? CNT_W'(slen32) : cap;
   assign slen_out = slen32[LEN_W-1:0];

   // Space a popped record gives back
   assign total    = 18'(slen32[15:0]) + 18'(HEADER_BYTES);
   assign free_sum = 32'(free_ff) + 32'(total);

   // Status toward the controller
   always_comb begin
      stat.cmd           = cmd_ff;
      stat.fill_needed   = (rem_ff != '0) && !drop_ff;
      stat.fits          = fits;
      stat.len_zero      = (len_m == '0);
      stat.empty         = (free_ff >= FREE_W'(QUEUE_BYTES));
      stat.hdr_last      = (idx_ff == IDX_W'(HEADER_BYTES - 1));
      stat.hdr_read_done = (idx_ff == IDX_W'(HEADER_BYTES));
      stat.n_zero        = (n_calc == '0);
      stat.stream_last   = pend_ff && ((out_cnt_ff + CNT_W'(1)) == n_ff);
   end

   // Next-state logic for every datapath operation
   always_comb begin
      cmd_in        = cmd_ff;
      byte_in       = byte_ff;
      len_in        = len_ff;
      want_in       = want_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      ptr_in        = ptr_ff;
      free_in       = free_ff;
      rem_in        = rem_ff;
      drop_in       = drop_ff;
      idx_in        = idx_ff;
      slen_in       = slen_ff;
      n_in          = n_ff;
      iss_in        = iss_ff;
      out_cnt_in    = out_cnt_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_slen_in   = rsp_slen_ff;
      rsp_free_in   = rsp_free_ff;
      pend_in       = (op == OP_RD_STREAM) && (iss_ff < n_ff);

      unique case (op)
         OP_NONE: begin
         end
         OP_CAPTURE: begin
            cmd_in    = cmd_type'(req_cmd);
            byte_in   = req_push_byte;
            len_in    = req_record_len;
            want_in   = req_max_bytes;
            status_in = STAT_OK;
            slen_in   = '0;
         end
         // Pad a short record with zero bytes
         OP_FILL: begin
            wr_en   = 1'b1;
            tail_in = tail_ff + ADDR_W'(1);
            rem_in  = rem_ff - LEN_W'(1);
         end
         OP_CLOSE: begin
            rem_in  = '0;
            drop_in = 1'b0;
         end
         // Reserve space or answer no-room and drop the rest of the record
         OP_PUSH_CHK: begin
            idx_in = '0;
            if (fits) begin
               free_in = free_ff - FREE_W'(need);
            end else begin
               status_in = STAT_NOROOM;
               rem_in    = (len_m == '0) ? '0 : LEN_W'(len_m - HDR_W'(1));
               drop_in   = (32'(len_m) > 32'd1);
            end
         end
         OP_HDR: begin
            wr_en   = 1'b1;
            wr_data = hdr_byte;
            tail_in = tail_ff + ADDR_W'(1);
            idx_in  = idx_ff + IDX_W'(1);
         end
         OP_DATA: begin
            wr_en   = 1'b1;
            wr_data = byte_ff;
            tail_in = tail_ff + ADDR_W'(1);
            rem_in  = LEN_W'(len_m - HDR_W'(1));
         end
         // Continuation byte of a record in progress
         OP_PUSH_NF: begin
            if (rem_ff != '0) begin
               if (!drop_ff) begin
                  wr_en   = 1'b1;
                  wr_data = byte_ff;
                  tail_in = tail_ff + ADDR_W'(1);
               end
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  drop_in = 1'b0;
               end
            end
         end
         OP_CLEAR: begin
            tail_in = head_ff;
            free_in = FREE_W'(QUEUE_BYTES);
            rem_in  = '0;
            drop_in = 1'b0;
         end
         OP_RD_START: begin
            ptr_in  = head_ff;
            idx_in  = '0;
            slen_in = '0;
            if (free_ff >= FREE_W'(QUEUE_BYTES)) begin
               status_in = STAT_EMPTY;
            end
         end
         // Header read: issue one address per cycle, collect each byte from the registered read output
         OP_RD_HDR: begin
            if (idx_ff < IDX_W'(HEADER_BYTES)) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + ADDR_W'(1);
            end
            for (int i = 0; i < HEADER_BYTES; i++) begin
               if (idx_ff == IDX_W'(i + 1)) begin
                  slen_in[BYTE_W*i +: BYTE_W] = rd_data_ff;
               end
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         // Read count; a pop frees the whole record
         OP_RD_CALC: begin
            n_in       = n_calc;
            iss_in     = '0;
            out_cnt_in = '0;
            if (cmd_ff == CMD_POP) begin
               head_in = head_ff + total[ADDR_W-1:0];
               free_in = (free_sum >= 32'(QUEUE_BYTES)) ? FREE_W'(QUEUE_BYTES)
                                                        : free_sum[FREE_W-1:0];
            end
         end
         // Stream data bytes, reads running one beat ahead of results
         OP_RD_STREAM: begin
            if (iss_ff < n_ff) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + ADDR_W'(1);
               iss_in = iss_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_byte_in   = rd_data_ff;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = ((out_cnt_ff + CNT_W'(1)) == n_ff);
               rsp_slen_in   = slen_out;
               rsp_free_in   = free_ff;
               out_cnt_in    = out_cnt_ff + CNT_W'(1);
            end
         end
         // Single-beat answer
         OP_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_byte_in   = '0;
            rsp_bvalid_in = 1'b0;
            rsp_last_in   = 1'b1;
            rsp_slen_in   = slen_out;
            rsp_free_in   = free_ff;
         end
         default: begin
         end
      endcase
   end

   // Ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= FREE_W'(QUEUE_BYTES);
         rem_ff       <= '0;
         drop_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rem_ff       <= rem_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      byte_ff       <= byte_in;
      len_ff        <= len_in;
      want_ff       <= want_in;
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      slen_ff       <= slen_in;
      n_ff          <= n_in;
      iss_ff        <= iss_in;
      out_cnt_ff    <= out_cnt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_slen_ff   <= rsp_slen_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_stored_len = rsp_slen_ff;
   assign rsp_free_bytes = rsp_free_ff;

endmodule

// ===== design/vrrf_checker.sv =====
// Port-level checker for the record ring FIFO, bound to the top level.
module vrrf_checker
   import vrrf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_byte_valid,
   input logic                rsp_last,
   input logic [FREE_W-1:0]   rsp_free_bytes
);

   // An accepted item always raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // A data stream has no gaps between beats
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a result stream");

   // Error answers are single beats without data
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_last && !rsp_byte_valid))
      else $error("error answer carries data or is not last");

   // Free space never exceeds the ring size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_bytes <= FREE_W'(QUEUE_BYTES)))
      else $error("free space above ring size");

   // Beats without data carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_out_byte == '0))
      else $error("non-data beat has nonzero byte");

endmodule

bind variable_record_ring_fifo vrrf_checker u_vrrf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_last       (rsp_last),
   .rsp_free_bytes (rsp_free_bytes)
);

// ===== sim/vrrf_checker.sv =====
// Watches the record FIFO channels, predicts every response beat and compares it.
module vrrf_scoreboard
   import vrrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [BYTE_W-1:0]   req_push_byte,
   input  logic                req_first_of_record,
   input  logic [LEN_W-1:0]    req_record_len,
   input  logic [WANT_W-1:0]   req_max_bytes,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [BYTE_W-1:0]   rsp_out_byte,
   input  logic                rsp_byte_valid,
   input  logic                rsp_last,
   input  logic [LEN_W-1:0]    rsp_stored_len,
   input  logic [FREE_W-1:0]   rsp_free_bytes,
   output int                  mismatches,
   output int                  beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   data;
      logic                data_valid;
      logic                last;
      logic [LEN_W-1:0]    slen;
      logic [FREE_W-1:0]   free;
   } rsp_beat_type;

   // Shadow copy of the ring and its bookkeeping
   logic [BYTE_W-1:0] ring_mem [QUEUE_BYTES];
   logic [ADDR_W-1:0] rd_ptr;
   logic [ADDR_W-1:0] wr_ptr;
   int unsigned       free_cnt;
   int unsigned       fill_left;
   bit                fill_drop;

   // Beats still owed by the block, oldest first
   rsp_beat_type beats_due [$];

   function automatic void queue_beat(status_type st, logic [BYTE_W-1:0] b, logic v,
                                      logic l, int unsigned slen);
      rsp_beat_type beat;
      beat.status     = st;
      beat.data       = b;
      beat.data_valid = v;
      beat.last       = l;
      beat.slen       = slen[LEN_W-1:0];
      beat.free       = free_cnt[FREE_W-1:0];
      beats_due.push_back(beat);
   endfunction

   function automatic void ring_write(logic [BYTE_W-1:0] b);
      ring_mem[wr_ptr] = b;
      wr_ptr           = wr_ptr + 1'b1;
   endfunction

   // An unfinished stored record gets zero padding; a dropped one just ends
   function automatic void close_record();
      if (!fill_drop) begin
         while (fill_left != 0) begin
            ring_write('0);
            fill_left--;
         end
      end
      fill_left = 0;
      fill_drop = 1'b0;
   endfunction

   function automatic void predict_push(logic [BYTE_W-1:0] b, logic first,
                                        logic [LEN_W-1:0] len);
      status_type  st;
      int unsigned need;
      st = STAT_OK;
      if (first) begin
         need = len + HEADER_BYTES;
         close_record();
         if (free_cnt < need) begin
            st        = STAT_NOROOM;
            fill_left = (len != 0) ? len - 1 : 0;
            fill_drop = (fill_left != 0);
         end else begin
            free_cnt -= need;
            for (int i = 0; i < HEADER_BYTES; i++)
               ring_write(BYTE_W'(32'(len) >> (8 * i)));
            if (len != 0) begin
               ring_write(b);
               fill_left = len - 1;
            end
         end
      end else if (fill_left != 0) begin
         if (!fill_drop)
            ring_write(b);
         fill_left--;
         if (fill_left == 0)
            fill_drop = 1'b0;
      end
      queue_beat(st, '0, 1'b0, 1'b1, 0);
   endfunction

   function automatic void predict_read(logic [WANT_W-1:0] want, bit pop);
      logic [ADDR_W-1:0] p;
      int unsigned       slen;
      int unsigned       cnt;
      int unsigned       total;
      close_record();
      if (free_cnt >= QUEUE_BYTES) begin
         queue_beat(STAT_EMPTY, '0, 1'b0, 1'b1, 0);
         return;
      end
      // little-endian length header
      p    = rd_ptr;
      slen = 0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         slen |= 32'(ring_mem[p]) << (8 * i);
         p = p + 1'b1;
      end
      cnt = slen;
      if (cnt > 32'(want)) cnt = 32'(want);
      if (cnt > MAX_READ) cnt = MAX_READ;
      if (pop) begin
         total    = HEADER_BYTES + (slen & 32'hFFFF);
         rd_ptr   = rd_ptr + total[ADDR_W-1:0];
         free_cnt = (free_cnt + total >= QUEUE_BYTES) ? QUEUE_BYTES : free_cnt + total;
      end
      if (cnt == 0) begin
         queue_beat(STAT_OK, '0, 1'b0, 1'b1, slen);
      end else begin
         for (int unsigned i = 0; i < cnt; i++) begin
            queue_beat(STAT_OK, ring_mem[p], 1'b1, (i + 1 == cnt), slen);
            p = p + 1'b1;
         end
      end
   endfunction

   function automatic void predict_clear();
      wr_ptr    = rd_ptr;
      free_cnt  = QUEUE_BYTES;
      fill_left = 0;
      fill_drop = 1'b0;
      queue_beat(STAT_OK, '0, 1'b0, 1'b1, 0);
   endfunction

   function automatic string beat_text(rsp_beat_type b);
      return $sformatf("status=%0d byte=%02h bv=%0d last=%0d len=%0d free=%0d",
                       b.status, b.data, b.data_valid, b.last, b.slen, b.free);
   endfunction

   function automatic void log_mismatch(string what, rsp_beat_type due, rsp_beat_type seen);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: exp %s | got %s", $realtime, what, beat_text(due),
                  beat_text(seen));
   endfunction

   // Compare the outgoing beat first, then predict for the beat taken at this edge
   always @(posedge clock) begin
      rsp_beat_type seen;
      rsp_beat_type due;
      if (reset) begin
         rd_ptr    = '0;
         wr_ptr    = '0;
         free_cnt  = QUEUE_BYTES;
         fill_left = 0;
         fill_drop = 1'b0;
         beats_due.delete();
      end else begin
         if (rsp_valid) begin
            seen.status     = status_type'(rsp_status);
            seen.data       = rsp_out_byte;
            seen.data_valid = rsp_byte_valid;
            seen.last       = rsp_last;
            seen.slen       = rsp_stored_len;
            seen.free       = rsp_free_bytes;
            if (beats_due.size() == 0) begin
               due = '0;
               log_mismatch("unexpected beat", due, seen);
            end else begin
               due = beats_due.pop_front();
               if (seen !== due)
                  log_mismatch("beat mismatch", due, seen);
            end
         end
         if (start && !busy) begin
            case (cmd_type'(req_cmd))
               CMD_PUSH: predict_push(req_push_byte, req_first_of_record, req_record_len);
               CMD_POP:  predict_read(req_max_bytes, 1'b1);
               CMD_PEEK: predict_read(req_max_bytes, 1'b0);
               default:  predict_clear();
            endcase
         end
      end
      beats_pending = beats_due.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top: clock, reset, stimulus for the record ring FIFO and the final verdict.
module tb
   import vrrf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd;
   logic [BYTE_W-1:0]   req_push_byte;
   logic                req_first_of_record;
   logic [LEN_W-1:0]    req_record_len;
   logic [WANT_W-1:0]   req_max_bytes;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last;
   logic [LEN_W-1:0]    rsp_stored_len;
   logic [FREE_W-1:0]   rsp_free_bytes;
   int                  mismatches;
   int                  beats_pending;

   int run_left = 0;   // beats left in the current back-to-back stretch

   always #10 clock = ~clock;

   variable_record_ring_fifo u_top (.*);

   vrrf_scoreboard u_checker (.*);

   // Present one beat at a falling edge after a random gap, hold until taken
   task automatic send_beat(input cmd_type c, input logic [BYTE_W-1:0] b,
                            input logic first, input logic [LEN_W-1:0] len,
                            input logic [WANT_W-1:0] want);
      int gap;
      gap = (run_left > 0) ? 0 : $urandom_range(0, 11);
      if (run_left > 0)
         run_left--;
      else if ($urandom_range(0, 7) == 0)
         run_left = $urandom_range(4, 24);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd             = c;
      req_push_byte       = b;
      req_first_of_record = first;
      req_record_len      = len;
      req_max_bytes       = want;
      start               = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // First beat of a record plus (nbytes - 1) data beats; don't-care fields random
   task automatic push_record(input int len, input int nbytes);
      send_beat(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b1, LEN_W'(len),
                WANT_W'($urandom_range(0, 127)));
      for (int i = 1; i < nbytes; i++)
         send_beat(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b0,
                   LEN_W'($urandom_range(0, 1023)), WANT_W'($urandom_range(0, 127)));
   endtask

   task automatic read_record(input cmd_type c);
      int want;
      want = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      send_beat(c, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                LEN_W'($urandom_range(0, 1023)), WANT_W'(want));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (beats_pending != 0) @(negedge clock);
   endtask

   // Hard stop in case the block hangs
   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int n_sent;
      int r;
      int len;
      int nbytes;
      reset               = 1'b1;
      start               = 1'b0;
      req_cmd             = CMD_PUSH;
      req_push_byte       = '0;
      req_first_of_record = 1'b0;
      req_record_len      = '0;
      req_max_bytes       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty reads, stray byte, zero-length record
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd64);
      send_beat(CMD_PEEK, 8'h00, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_PUSH, 8'h5A, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_PUSH, 8'hFF, 1'b1, 10'd0, 7'd0);
      send_beat(CMD_PEEK, 8'h00, 1'b0, 10'd0, 7'd127);
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd1);
      // short record, truncated peek, oversized pop count
      send_beat(CMD_PUSH, 8'h00, 1'b1, 10'd3, 7'd0);
      send_beat(CMD_PUSH, 8'hFF, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_PUSH, 8'hA5, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_PEEK, 8'h00, 1'b0, 10'd0, 7'd2);
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd127);
      // fill the ring exactly (wraps), then no-room with padding, dropping, zero length
      send_beat(CMD_PUSH, 8'hFF, 1'b1, 10'd1020, 7'd0);
      send_beat(CMD_PUSH, 8'h12, 1'b1, 10'd1023, 7'd0);
      send_beat(CMD_PUSH, 8'h34, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_PUSH, 8'h56, 1'b1, 10'd0, 7'd0);
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd64);
      wait_drained();
      // peek with zero count interrupts an unfinished record
      send_beat(CMD_PUSH, 8'h33, 1'b1, 10'd2, 7'd0);
      send_beat(CMD_PEEK, 8'h00, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd64);
      // clear abandons a push in progress
      send_beat(CMD_PUSH, 8'h11, 1'b1, 10'd10, 7'd0);
      send_beat(CMD_PUSH, 8'h22, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_CLEAR, 8'h00, 1'b0, 10'd0, 7'd0);
      send_beat(CMD_POP,  8'h00, 1'b0, 10'd0, 7'd64);
      send_beat(CMD_PUSH, 8'h80, 1'b1, 10'd4, 7'd0);
      send_beat(CMD_PUSH, 8'h7F, 1'b0, 10'd0, 7'd0);
      n_sent = 25;

      // Random: mostly whole records and reads, some cut-off records and noise
      while (n_sent < 270) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
            nbytes = (len == 0) ? 1 : len;
            push_record(len, nbytes);
            n_sent += nbytes;
         end else if (r < 55) begin
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(1, 40);
            nbytes = (len < 2) ? 1 : $urandom_range(1, (len < 4) ? len - 1 : 4);
            push_record(len, nbytes);
            n_sent += nbytes;
         end else if (r < 80) begin
            read_record(CMD_POP);
            n_sent++;
         end else if (r < 92) begin
            read_record(CMD_PEEK);
            n_sent++;
         end else if (r < 95) begin
            send_beat(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      LEN_W'($urandom_range(0, 1023)), WANT_W'($urandom_range(0, 127)));
            n_sent++;
         end else if (r < 98) begin
            // stray data byte: continues a cut-off record if one is open
            send_beat(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b0,
                      LEN_W'($urandom_range(0, 1023)), WANT_W'($urandom_range(0, 127)));
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
